[rtl/rfa_pkg.sv]
// Shared constants, codes and controller/datapath types of the rational fraction unit.
package rfa_pkg;

	localparam int DEF_WORD_BITS = 32;
	localparam int FIELD_BITS    = 32;

	localparam logic [2:0] CMD_MUL      = 3'd0;
	localparam logic [2:0] CMD_SUB      = 3'd1;
	localparam logic [2:0] CMD_CMP      = 3'd2;
	localparam logic [2:0] CMD_INV      = 3'd3;
	localparam logic [2:0] CMD_SIMP     = 3'd4;
	localparam logic [2:0] CMD_FROM_INT = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVF      = 2'd1;
	localparam logic [1:0] ST_INV_ZERO = 2'd2;

	localparam logic signed [1:0] ORD_LESS    = -2'sd1;
	localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
	localparam logic signed [1:0] ORD_GREATER = 2'sd1;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_A,
		OP_MUL_B,
		OP_SIMP,
		OP_GCD_INIT_S,
		OP_GCD_INIT_R,
		OP_GCD_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SMUL,
		OP_COMB,
		OP_FIN
	} dp_op_t;

	// Operand/destination select for divisions and for the subtract products.
	typedef enum logic [1:0] {
		SEL_M1,
		SEL_M2,
		SEL_DEN,
		SEL_NUM
	} dp_sel_t;

	typedef struct packed {
		dp_op_t  op;
		dp_sel_t sel;
		logic    last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic       gcd_done;
		logic       g_zero;
		logic       num_zero;
		logic       den_zero;
		logic       out_free;
	} dp_stat_t;

	typedef struct packed {
		logic [2:0]               command;
		logic                     a_negative;
		logic [FIELD_BITS-1:0]    a_numerator;
		logic [FIELD_BITS-1:0]    a_denominator;
		logic                     b_negative;
		logic [FIELD_BITS-1:0]    b_numerator;
		logic [FIELD_BITS-1:0]    b_denominator;
		logic signed [FIELD_BITS-1:0] int_value;
	} in_word_t;

endpackage

[rtl/rfa_if.sv]
// Handshake interfaces for the operand and result words.
interface rfa_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic        a_negative;
	logic [31:0] a_numerator;
	logic [31:0] a_denominator;
	logic        b_negative;
	logic [31:0] b_numerator;
	logic [31:0] b_denominator;
	logic signed [31:0] int_value;

	modport source (output valid, command, a_negative, a_numerator, a_denominator,
		b_negative, b_numerator, b_denominator, int_value, input ready);
	modport sink (input valid, command, a_negative, a_numerator, a_denominator,
		b_negative, b_numerator, b_denominator, int_value, output ready);
endinterface

interface rfa_out_if;
	logic        valid;
	logic        ready;
	logic        res_negative;
	logic [31:0] res_numerator;
	logic [31:0] res_denominator;
	logic signed [1:0] order;
	logic        was_reduced;
	logic [1:0]  status;

	modport source (output valid, res_negative, res_numerator, res_denominator, order,
		was_reduced, status, input ready);
	modport sink (input valid, res_negative, res_numerator, res_denominator, order,
		was_reduced, status, output ready);
endinterface

[rtl/rfa_ctrl.sv]
// Sequencing state machine of the rational fraction unit.
module rfa_ctrl #(
	parameter int WORD_BITS = rfa_pkg::DEF_WORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rfa_pkg::dp_stat_t  stat,
	output rfa_pkg::dp_cmd_t   cmd
);

	localparam int DIV_BITS = 2 * WORD_BITS + 1;
	localparam int CNT_BITS = $clog2(DIV_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

	typedef enum logic [19:0] {
		S_IDLE   = 20'h00001,
		S_DEC    = 20'h00002,
		S_MULA   = 20'h00004,
		S_MULB   = 20'h00008,
		S_SGCD   = 20'h00010,
		S_SDIV1I = 20'h00020,
		S_SDIV1  = 20'h00040,
		S_SDIV2I = 20'h00080,
		S_SDIV2  = 20'h00100,
		S_SMUL1  = 20'h00200,
		S_SMUL2  = 20'h00400,
		S_SMUL3  = 20'h00800,
		S_SCOMB  = 20'h01000,
		S_RCHK   = 20'h02000,
		S_RGCD   = 20'h04000,
		S_RDIV1I = 20'h08000,
		S_RDIV1  = 20'h10000,
		S_RDIV2I = 20'h20000,
		S_RDIV2  = 20'h40000,
		S_FIN    = 20'h80000
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic                div_last;

	assign div_last = (cnt_q == CNT_LAST);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '{op: rfa_pkg::OP_NOP, sel: rfa_pkg::SEL_M1, last: 1'b0};
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = rfa_pkg::OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (stat.command)
					rfa_pkg::CMD_MUL, rfa_pkg::CMD_CMP: state_d = S_MULA;
					rfa_pkg::CMD_SIMP: begin
						cmd.op  = rfa_pkg::OP_SIMP;
						state_d = S_RCHK;
					end
					rfa_pkg::CMD_SUB: begin
						cmd.op  = rfa_pkg::OP_GCD_INIT_S;
						state_d = S_SGCD;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_MULA: begin
				cmd.op  = rfa_pkg::OP_MUL_A;
				state_d = S_MULB;
			end
			S_MULB: begin
				cmd.op  = rfa_pkg::OP_MUL_B;
				state_d = (stat.command == rfa_pkg::CMD_CMP) ? S_FIN : S_RCHK;
			end
			S_SGCD: begin
				cmd.op = rfa_pkg::OP_GCD_STEP;
				if (stat.gcd_done) begin
					state_d = S_SDIV1I;
				end
			end
			S_SDIV1I: begin
				// Both denominators zero: the scale factors stay at one.
				if (stat.g_zero) begin
					state_d = S_SMUL1;
				end else begin
					cmd.op  = rfa_pkg::OP_DIV_INIT;
					cmd.sel = rfa_pkg::SEL_M1;
					state_d = S_SDIV1;
				end
			end
			S_SDIV1: begin
				cmd = '{op: rfa_pkg::OP_DIV_STEP, sel: rfa_pkg::SEL_M1, last: div_last};
				if (div_last) begin
					state_d = S_SDIV2I;
				end
			end
			S_SDIV2I: begin
				cmd.op  = rfa_pkg::OP_DIV_INIT;
				cmd.sel = rfa_pkg::SEL_M2;
				state_d = S_SDIV2;
			end
			S_SDIV2: begin
				cmd = '{op: rfa_pkg::OP_DIV_STEP, sel: rfa_pkg::SEL_M2, last: div_last};
				if (div_last) begin
					state_d = S_SMUL1;
				end
			end
			S_SMUL1: begin
				cmd.op  = rfa_pkg::OP_SMUL;
				cmd.sel = rfa_pkg::SEL_DEN;
				state_d = S_SMUL2;
			end
			S_SMUL2: begin
				cmd.op  = rfa_pkg::OP_SMUL;
				cmd.sel = rfa_pkg::SEL_M1;
				state_d = S_SMUL3;
			end
			S_SMUL3: begin
				cmd.op  = rfa_pkg::OP_SMUL;
				cmd.sel = rfa_pkg::SEL_M2;
				state_d = S_SCOMB;
			end
			S_SCOMB: begin
				cmd.op  = rfa_pkg::OP_COMB;
				state_d = S_RCHK;
			end
			S_RCHK: begin
				if (stat.num_zero || stat.den_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = rfa_pkg::OP_GCD_INIT_R;
					state_d = S_RGCD;
				end
			end
			S_RGCD: begin
				cmd.op = rfa_pkg::OP_GCD_STEP;
				if (stat.gcd_done) begin
					state_d = S_RDIV1I;
				end
			end
			S_RDIV1I: begin
				cmd.op  = rfa_pkg::OP_DIV_INIT;
				cmd.sel = rfa_pkg::SEL_DEN;
				state_d = S_RDIV1;
			end
			S_RDIV1: begin
				cmd = '{op: rfa_pkg::OP_DIV_STEP, sel: rfa_pkg::SEL_DEN, last: div_last};
				if (div_last) begin
					state_d = S_RDIV2I;
				end
			end
			S_RDIV2I: begin
				cmd.op  = rfa_pkg::OP_DIV_INIT;
				cmd.sel = rfa_pkg::SEL_NUM;
				state_d = S_RDIV2;
			end
			S_RDIV2: begin
				cmd = '{op: rfa_pkg::OP_DIV_STEP, sel: rfa_pkg::SEL_NUM, last: div_last};
				if (div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.op  = rfa_pkg::OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.op == rfa_pkg::OP_DIV_INIT) begin
				cnt_q <= '0;
			end else if (cmd.op == rfa_pkg::OP_DIV_STEP) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DEC)
		else $error("accepted word not followed by decode");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == rfa_pkg::OP_FIN |-> stat.out_free)
		else $error("result written while output register is occupied");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == rfa_pkg::OP_DIV_STEP |-> !stat.g_zero)
		else $error("division by a zero common divisor");

endmodule

[rtl/rfa_dp.sv]
// Datapath: operand registers, shared multiplier, binary GCD, bit-serial divider, result.
module rfa_dp #(
	parameter int WORD_BITS = rfa_pkg::DEF_WORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rfa_pkg::in_word_t  in_word,
	input  rfa_pkg::dp_cmd_t   cmd,
	output rfa_pkg::dp_stat_t  stat,
	rfa_out_if.source          result
);

	localparam int W  = WORD_BITS;
	localparam int DB = 2 * WORD_BITS;
	localparam int NB = 2 * WORD_BITS + 1;
	localparam int KB = $clog2(NB + 1);
	localparam int FB = rfa_pkg::FIELD_BITS;

	logic [2:0]   cmd_q;
	logic         an_q, bn_q, sgn_q;
	logic [W-1:0] anum_q, aden_q, bnum_q, bden_q, m1_q, m2_q;
	logic [FB-1:0] iv_q;
	logic [NB-1:0] num_q, gu_q, gv_q, quo_q, qq_q;
	logic [DB-1:0] den_q, t1_q, t2_q, g_q, rem_q, dq_q;
	logic [KB-1:0] gk_q;

	logic [W-1:0]  mul_a, mul_b;
	logic [DB-1:0] mul_p;
	logic          gcd_done;
	logic [NB-1:0] g_full;
	logic [NB-1:0] trial, trial_sub, quo_next;
	logic          trial_ge;
	logic [NB-1:0] sum;
	logic [DB-1:0] diff;
	logic          t1_ge, sb_neg;

	logic          out_valid_q;
	logic          res_neg_q, res_red_q;
	logic [FB-1:0] res_num_q, res_den_q;
	logic signed [1:0] res_ord_q;
	logic [1:0]    res_st_q;

	logic          r_neg, r_red, is_simp, ca_neg, cb_neg;
	logic [W-1:0]  r_num, r_den;
	logic signed [1:0] r_ord;
	logic [1:0]    r_st;
	logic [FB-1:0] iv_mag;

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = anum_q;
		mul_b = bnum_q;
		case (cmd.op)
			rfa_pkg::OP_MUL_A: mul_b = (cmd_q == rfa_pkg::CMD_CMP) ? bden_q : bnum_q;
			rfa_pkg::OP_MUL_B: begin
				mul_a = (cmd_q == rfa_pkg::CMD_CMP) ? bnum_q : bden_q;
				mul_b = aden_q;
			end
			rfa_pkg::OP_SMUL: begin
				case (cmd.sel)
					rfa_pkg::SEL_DEN: begin
						mul_a = aden_q;
						mul_b = m1_q;
					end
					rfa_pkg::SEL_M1: begin
						mul_a = anum_q;
						mul_b = m1_q;
					end
					default: begin
						mul_a = bnum_q;
						mul_b = m2_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign mul_p = DB'(mul_a) * DB'(mul_b);

	assign gcd_done = (gu_q == '0) || (gv_q == '0);
	assign g_full   = (gu_q | gv_q) << gk_q;

	assign trial     = {rem_q, quo_q[NB-1]};
	assign trial_ge  = (trial >= {1'b0, g_q});
	assign trial_sub = trial - {1'b0, g_q};
	assign quo_next  = {quo_q[NB-2:0], trial_ge};

	// Signed sum or difference of the scaled numerators, b taken with its sign flipped.
	assign sb_neg = ~bn_q;
	assign sum    = {1'b0, t1_q} + {1'b0, t2_q};
	assign t1_ge  = (t1_q >= t2_q);
	assign diff   = t1_ge ? (t1_q - t2_q) : (t2_q - t1_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			rfa_pkg::OP_LOAD: begin
				cmd_q  <= in_word.command;
				an_q   <= in_word.a_negative;
				anum_q <= in_word.a_numerator[W-1:0];
				aden_q <= in_word.a_denominator[W-1:0];
				bn_q   <= in_word.b_negative;
				bnum_q <= in_word.b_numerator[W-1:0];
				bden_q <= in_word.b_denominator[W-1:0];
				iv_q   <= in_word.int_value;
			end
			rfa_pkg::OP_MUL_A: begin
				num_q <= NB'(mul_p);
				sgn_q <= an_q ^ bn_q;
			end
			rfa_pkg::OP_MUL_B: den_q <= mul_p;
			rfa_pkg::OP_SIMP: begin
				num_q <= NB'(anum_q);
				den_q <= DB'(aden_q);
				sgn_q <= an_q;
			end
			rfa_pkg::OP_GCD_INIT_S: begin
				gu_q <= NB'(aden_q);
				gv_q <= NB'(bden_q);
				gk_q <= '0;
				m1_q <= W'(1);
				m2_q <= W'(1);
			end
			rfa_pkg::OP_GCD_INIT_R: begin
				gu_q <= NB'(den_q);
				gv_q <= num_q;
				gk_q <= '0;
			end
			rfa_pkg::OP_GCD_STEP: begin
				if (gcd_done) begin
					g_q <= g_full[DB-1:0];
				end else if (!gu_q[0] && !gv_q[0]) begin
					gu_q <= gu_q >> 1;
					gv_q <= gv_q >> 1;
					gk_q <= gk_q + 1'b1;
				end else if (!gu_q[0]) begin
					gu_q <= gu_q >> 1;
				end else if (!gv_q[0]) begin
					gv_q <= gv_q >> 1;
				end else if (gu_q >= gv_q) begin
					gu_q <= gu_q - gv_q;
				end else begin
					gv_q <= gv_q - gu_q;
				end
			end
			rfa_pkg::OP_DIV_INIT: begin
				rem_q <= '0;
				case (cmd.sel)
					rfa_pkg::SEL_M1:  quo_q <= NB'(bden_q);
					rfa_pkg::SEL_M2:  quo_q <= NB'(aden_q);
					rfa_pkg::SEL_DEN: quo_q <= NB'(den_q);
					default:          quo_q <= num_q;
				endcase
			end
			rfa_pkg::OP_DIV_STEP: begin
				rem_q <= trial_ge ? trial_sub[DB-1:0] : trial[DB-1:0];
				quo_q <= quo_next;
				if (cmd.last) begin
					case (cmd.sel)
						rfa_pkg::SEL_M1:  m1_q <= quo_next[W-1:0];
						rfa_pkg::SEL_M2:  m2_q <= quo_next[W-1:0];
						rfa_pkg::SEL_DEN: dq_q <= quo_next[DB-1:0];
						default:          qq_q <= quo_next;
					endcase
				end
			end
			rfa_pkg::OP_SMUL: begin
				case (cmd.sel)
					rfa_pkg::SEL_DEN: den_q <= mul_p;
					rfa_pkg::SEL_M1:  t1_q  <= mul_p;
					default:          t2_q  <= mul_p;
				endcase
			end
			rfa_pkg::OP_COMB: begin
				if (an_q == sb_neg) begin
					num_q <= sum;
					sgn_q <= an_q;
				end else begin
					num_q <= NB'(diff);
					sgn_q <= t1_ge ? an_q : sb_neg;
				end
			end
			default: ;
		endcase
	end

	// Result formation from the finished working registers.
	assign is_simp = (cmd_q == rfa_pkg::CMD_SIMP);
	assign ca_neg  = an_q & (|anum_q);
	assign cb_neg  = bn_q & (|bnum_q);
	assign iv_mag  = iv_q[FB-1] ? (~iv_q + 1'b1) : iv_q;

	always_comb begin
		r_neg = 1'b0;
		r_num = '0;
		r_den = '0;
		r_ord = rfa_pkg::ORD_EQUAL;
		r_red = 1'b0;
		r_st  = rfa_pkg::ST_OK;
		case (cmd_q)
			rfa_pkg::CMD_MUL, rfa_pkg::CMD_SUB, rfa_pkg::CMD_SIMP: begin
				if (num_q == '0) begin
					r_den = W'(1);
					r_red = is_simp;
				end else if (den_q == '0) begin
					r_neg = sgn_q;
					r_num = W'(1);
					r_red = is_simp && (num_q != NB'(1));
				end else if ((|qq_q[NB-1:W]) || (|dq_q[DB-1:W])) begin
					r_st = rfa_pkg::ST_OVF;
				end else begin
					r_neg = sgn_q;
					r_num = qq_q[W-1:0];
					r_den = dq_q[W-1:0];
					r_red = is_simp && (g_q != DB'(1));
				end
			end
			rfa_pkg::CMD_CMP: begin
				if (!ca_neg && !cb_neg) begin
					r_ord = (num_q[DB-1:0] < den_q) ? rfa_pkg::ORD_LESS :
						((num_q[DB-1:0] > den_q) ? rfa_pkg::ORD_GREATER : rfa_pkg::ORD_EQUAL);
				end else if (ca_neg && cb_neg) begin
					r_ord = (num_q[DB-1:0] > den_q) ? rfa_pkg::ORD_LESS :
						((num_q[DB-1:0] < den_q) ? rfa_pkg::ORD_GREATER : rfa_pkg::ORD_EQUAL);
				end else if (!ca_neg) begin
					r_ord = rfa_pkg::ORD_GREATER;
				end else begin
					r_ord = rfa_pkg::ORD_LESS;
				end
			end
			rfa_pkg::CMD_INV: begin
				if (anum_q == '0) begin
					r_st = rfa_pkg::ST_INV_ZERO;
				end else begin
					r_neg = an_q;
					r_num = aden_q;
					r_den = anum_q;
				end
			end
			rfa_pkg::CMD_FROM_INT: begin
				if ((iv_mag >> WORD_BITS) != '0) begin
					r_st = rfa_pkg::ST_OVF;
				end else begin
					r_neg = iv_q[FB-1];
					r_num = iv_mag[W-1:0];
					r_den = W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == rfa_pkg::OP_FIN) begin
			res_neg_q <= r_neg;
			res_num_q <= FB'(r_num);
			res_den_q <= FB'(r_den);
			res_ord_q <= r_ord;
			res_red_q <= r_red;
			res_st_q  <= r_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == rfa_pkg::OP_FIN) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.res_negative    = res_neg_q;
	assign result.res_numerator   = res_num_q;
	assign result.res_denominator = res_den_q;
	assign result.order           = res_ord_q;
	assign result.was_reduced     = res_red_q;
	assign result.status          = res_st_q;

	assign stat.command  = cmd_q;
	assign stat.gcd_done = gcd_done;
	assign stat.g_zero   = (g_q == '0);
	assign stat.num_zero = (num_q == '0);
	assign stat.den_zero = (den_q == '0);
	assign stat.out_free = !out_valid_q || result.ready;

endmodule

[rtl/rational_fraction_alu.sv]
// Rational fraction arithmetic unit: operand channel in, result channel out, one word each.
// The operand word carries a command and two sign-magnitude fractions (or a signed integer);
// the unit returns one result word per operand word, in order. Both channels move a word
// when valid and ready are high at a rising clock edge.
// Only one operand word is worked on at a time. Invert, from-integer and unused commands
// go from decode straight to writing their result, and compare first forms its two cross
// products. A zero numerator or denominator ends simplify and multiply before any GCD or
// division. Otherwise multiply and simplify run a binary GCD (one shift or subtract a cycle)
// and two exact divisions on a bit-serial divider; subtract first adds a GCD of the
// denominators, two more divisions (skipped when both denominators are zero) and three
// multiplies on the one shared multiplier. The next operand word is accepted in the cycle
// after the result is written at the earliest.
// The result sits in an output register: while the receiver holds ready low it stays, and
// the unit accepts and works on the next operand word, stopping only when that result is
// ready to be written. Reset clears the controller and empties the output register; the
// operand channel is ready as soon as reset is released.
module rational_fraction_alu #(
	parameter int WORD_BITS = rfa_pkg::DEF_WORD_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	rfa_in_if.sink     operand,
	rfa_out_if.source  result
);

	rfa_pkg::dp_cmd_t  dcmd;
	rfa_pkg::dp_stat_t dstat;
	rfa_pkg::in_word_t in_word;
	logic              in_ready;

	assign operand.ready = in_ready;

	assign in_word = '{
		command:       operand.command,
		a_negative:    operand.a_negative,
		a_numerator:   operand.a_numerator,
		a_denominator: operand.a_denominator,
		b_negative:    operand.b_negative,
		b_numerator:   operand.b_numerator,
		b_denominator: operand.b_denominator,
		int_value:     operand.int_value
	};

	rfa_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operand.valid),
		.in_ready (in_ready),
		.stat     (dstat),
		.cmd      (dcmd)
	);

	rfa_dp #(.WORD_BITS(WORD_BITS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_word (in_word),
		.cmd     (dcmd),
		.stat    (dstat),
		.result  (result)
	);

endmodule

[tb/rfa_checker.sv]
// Result checker of the rational fraction unit: predicts every result word and compares it.
`timescale 1ns / 100ps

module rfa_checker #(
	parameter int WORD_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	rfa_in_if     operand,
	rfa_out_if    result,
	output int    errors,
	output int    outstanding
);
	import rfa_pkg::*;

	typedef struct packed {
		logic              neg;
		logic [31:0]       num;
		logic [31:0]       den;
		logic signed [1:0] order;
		logic              reduced;
		logic [1:0]        status;
	} fraction_t;

	localparam logic [63:0] WORD_MAX = (64'd1 << WORD_BITS) - 64'd1;

	fraction_t awaited[$];

	function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = y;
			y = x % y;
			x = t;
		end
		return x;
	endfunction

	// Reduces value/den; returns 1 when the reduced fraction does not fit in a word.
	function automatic logic lowest_terms(logic [127:0] value, logic [63:0] den,
			output logic [63:0] num_o, output logic [63:0] den_o, output logic changed);
		logic [63:0] g;
		logic [127:0] q;
		num_o = 0;
		den_o = 0;
		changed = 0;
		if (value == 0) begin
			den_o = 1;
			changed = 1;
			return 0;
		end
		if (den == 0) begin
			num_o = 1;
			changed = (value != 1);
			return 0;
		end
		g = euclid(den, 64'(value % den));
		changed = (g != 1);
		q = value / g;
		if (q > WORD_MAX || den / g > WORD_MAX)
			return 1;
		num_o = q[63:0];
		den_o = den / g;
		return 0;
	endfunction

	function automatic fraction_t fraction_result(in_word_t w);
		fraction_t r;
		logic [63:0] an, ad, bn, bd, iv, g, m1, m2, t1, t2, den, n, d, l, rt, mag;
		logic [127:0] value;
		logic sgn, sb, sa, ch;
		r = '0;
		an = w.a_numerator & WORD_MAX;
		ad = w.a_denominator & WORD_MAX;
		bn = w.b_numerator & WORD_MAX;
		bd = w.b_denominator & WORD_MAX;
		iv = {32'd0, w.int_value};
		case (w.command)
			CMD_MUL, CMD_SUB, CMD_SIMP: begin
				if (w.command == CMD_MUL) begin
					sgn = w.a_negative ^ w.b_negative;
					value = an * bn;
					den = ad * bd;
				end else if (w.command == CMD_SIMP) begin
					sgn = w.a_negative;
					value = an;
					den = ad;
				end else begin
					g = euclid(ad, bd);
					m1 = 1;
					m2 = 1;
					if (g != 0) begin
						m1 = bd / g;
						m2 = ad / g;
					end
					den = ad * m1;
					t1 = an * m1;
					t2 = bn * m2;
					sb = ~w.b_negative;
					if (w.a_negative == sb) begin
						value = 128'(t1) + 128'(t2);
						sgn = w.a_negative;
					end else if (t1 >= t2) begin
						value = t1 - t2;
						sgn = w.a_negative;
					end else begin
						value = t2 - t1;
						sgn = sb;
					end
				end
				if (lowest_terms(value, den, n, d, ch)) begin
					r.status = ST_OVF;
				end else begin
					r.num = n[31:0];
					r.den = d[31:0];
					r.neg = (n == 0) ? 1'b0 : sgn;
					if (w.command == CMD_SIMP)
						r.reduced = ch;
				end
			end
			CMD_CMP: begin
				l = an * bd;
				rt = bn * ad;
				sa = (an != 0) && w.a_negative;
				sb = (bn != 0) && w.b_negative;
				if (!sa && !sb)
					r.order = (l < rt) ? ORD_LESS : (l > rt) ? ORD_GREATER : ORD_EQUAL;
				else if (sa && sb)
					r.order = (l > rt) ? ORD_LESS : (l < rt) ? ORD_GREATER : ORD_EQUAL;
				else
					r.order = sa ? ORD_LESS : ORD_GREATER;
			end
			CMD_INV: begin
				if (an == 0) begin
					r.status = ST_INV_ZERO;
				end else begin
					r.neg = w.a_negative;
					r.num = ad[31:0];
					r.den = an[31:0];
				end
			end
			CMD_FROM_INT: begin
				mag = iv[31] ? ((64'd0 - iv) & 64'hFFFF_FFFF) : iv;
				if (mag == 0 && iv[31])
					mag = 64'h8000_0000;
				if (mag > WORD_MAX) begin
					r.status = ST_OVF;
				end else begin
					r.neg = iv[31];
					r.num = mag[31:0];
					r.den = 32'd1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	assign outstanding = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		fraction_t got, want;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (operand.valid && operand.ready)
				awaited.push_back(fraction_result('{operand.command, operand.a_negative,
					operand.a_numerator, operand.a_denominator, operand.b_negative,
					operand.b_numerator, operand.b_denominator, operand.int_value}));
			if (result.valid && result.ready) begin
				got = '{result.res_negative, result.res_numerator, result.res_denominator,
					result.order, result.was_reduced, result.status};
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %h",
						$realtime, got);
					errors <= errors + 1;
				end else begin
					want = awaited.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch, expected neg %b num %h den %h ord %0d red %b st %0d, actual neg %b num %h den %h ord %0d red %b st %0d",
							$realtime, want.neg, want.num, want.den, want.order, want.reduced,
							want.status, got.neg, got.num, got.den, got.order, got.reduced,
							got.status);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

[tb/rational_fraction_alu_tb.sv]
// Stimulus and verdict for the rational fraction unit testbench.
`timescale 1ns / 100ps

module rational_fraction_alu_tb;
	import rfa_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;

	rfa_in_if  opnd();
	rfa_out_if res();

	rational_fraction_alu dut (.clk(clk), .arst_n(arst_n), .operand(opnd), .result(res));

	rfa_checker checker_i (.clk(clk), .arst_n(arst_n), .operand(opnd), .result(res),
		.errors(errors), .outstanding(outstanding));

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Mostly no pause, sometimes a short one, now and then a long one.
	function automatic int pause_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 93)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	function automatic logic [31:0] magnitude(bit nonzero);
		logic [31:0] m;
		case ($urandom_range(0, 9))
			0: m = 32'hFFFF_FFFF;
			1: m = $urandom_range(0, 1);
			2, 3, 4: m = $urandom_range(0, 60);
			5, 6: m = $urandom_range(0, 60) * $urandom_range(1, 40);
			7: m = $urandom_range(0, 16'hFFFF);
			default: m = $urandom;
		endcase
		if (nonzero && m == 0)
			m = 1;
		return m;
	endfunction

	task automatic send(logic [2:0] c, logic as, logic [31:0] an, logic [31:0] ad,
			logic bs, logic [31:0] bn, logic [31:0] bd, logic [31:0] iv);
		int gap;
		opnd.valid         <= 1'b1;
		opnd.command       <= c;
		opnd.a_negative    <= as;
		opnd.a_numerator   <= an;
		opnd.a_denominator <= ad;
		opnd.b_negative    <= bs;
		opnd.b_numerator   <= bn;
		opnd.b_denominator <= bd;
		opnd.int_value     <= iv;
		do @(posedge clk); while (!opnd.ready);
		@(negedge clk);
		gap = pause_len();
		if (gap > 0) begin
			opnd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Receiver: ready low for a random stretch, then high for a random stretch.
	initial begin
		int hold;
		res.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = pause_len();
			if (hold > 0) begin
				res.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	initial begin
		logic [2:0] c;
		int waited;
		opnd.valid = 0;
		opnd.command = CMD_MUL;
		opnd.a_negative = 0;
		opnd.a_numerator = 0;
		opnd.a_denominator = 1;
		opnd.b_negative = 0;
		opnd.b_numerator = 0;
		opnd.b_denominator = 1;
		opnd.int_value = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send(CMD_MUL, 0, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1, 0);
		send(CMD_MUL, 1, 0, 7, 0, 5, 3, 0);
		send(CMD_MUL, 1, 6, 35, 1, 14, 9, 32'hFFFF_FFFF);
		send(CMD_MUL, 0, 1, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 0);
		send(CMD_SUB, 0, 3, 4, 0, 3, 4, 0);
		send(CMD_SUB, 0, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1, 0);
		send(CMD_SUB, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0);
		send(CMD_SUB, 1, 1, 6, 1, 1, 3, 0);
		send(CMD_SUB, 0, 1, 6, 0, 1, 3, 0);
		send(CMD_CMP, 1, 0, 5, 0, 0, 9, 0);
		send(CMD_CMP, 1, 1, 2, 1, 1, 3, 0);
		send(CMD_CMP, 0, 2, 4, 0, 1, 2, 0);
		send(CMD_CMP, 0, 1, 3, 1, 5, 1, 0);
		send(CMD_CMP, 1, 32'hFFFF_FFFF, 1, 0, 0, 32'hFFFF_FFFF, 0);
		send(CMD_INV, 1, 0, 4, 0, 0, 1, 0);
		send(CMD_INV, 1, 6, 32'hFFFF_FFFF, 0, 0, 1, 0);
		send(CMD_SIMP, 1, 6, 4, 0, 0, 1, 0);
		send(CMD_SIMP, 0, 7, 3, 0, 0, 1, 0);
		send(CMD_SIMP, 1, 0, 32'hFFFF_FFFF, 0, 0, 1, 0);
		send(CMD_FROM_INT, 0, 0, 1, 0, 0, 1, 0);
		send(CMD_FROM_INT, 0, 0, 1, 0, 0, 1, 32'hFFFF_FFFF);
		send(CMD_FROM_INT, 0, 0, 1, 0, 0, 1, 32'h8000_0000);
		send(CMD_FROM_INT, 0, 0, 1, 0, 0, 1, 32'h7FFF_FFFF);

		repeat (550) begin
			c = 3'($urandom_range(CMD_MUL, CMD_FROM_INT));
			send(c, 1'($urandom), magnitude(0), magnitude(1), 1'($urandom), magnitude(0),
				magnitude(1), ($urandom_range(0, 3) == 0) ? 32'(magnitude(0)) : $urandom);
		end
		@(negedge clk);
		opnd.valid <= 1'b0;

		waited = 0;
		while (outstanding != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (800) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
